FILE: hdl/blf_pkg.sv
package blf_pkg;

  // configuration register layout
  localparam int unsigned CFG_DATA_WIDTH = 16;
  localparam int unsigned CFG_ADDR_WIDTH = 1;

  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_COURANT_RATIO  = 1'b0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ALTERNATE_MODE = 1'b1;

  // courant ratio format: unsigned, 14 fraction bits
  localparam int unsigned COURANT_WIDTH = 16;
  localparam int unsigned COURANT_FRAC  = 14;
  // scaled difference r*D is taken down by 2^(frac+2) (the factor 1/4)
  localparam int unsigned SPLIT_BITS    = COURANT_FRAC + 2;

  localparam logic [COURANT_WIDTH-1:0] COURANT_RESET = 16'd14746;
  localparam logic                     ALT_MODE_RESET = 1'b1;

  // buffered sample count codes
  localparam logic [1:0] BUF_EMPTY  = 2'd0;
  localparam logic [1:0] BUF_CENTER = 2'd1;
  localparam logic [1:0] BUF_PAIR   = 2'd2;

  // operand select of the shared multiplier
  typedef enum logic [1:0] {
    MUL_SQ_RIGHT,
    MUL_SQ_LEFT,
    MUL_SCALE
  } mul_sel_e;

  typedef struct packed {
    logic     en;
    mul_sel_e sel;
  } mul_ctrl_t;

endpackage

FILE: hdl/blf_mul.sv
module blf_mul #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  blf_pkg::mul_ctrl_t                ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    left_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    right_i,
  input  logic [blf_pkg::COURANT_WIDTH-1:0] courant_i,
  input  logic signed [2*SAMPLE_WIDTH-1:0]  diff_i,
  output logic signed [((SAMPLE_WIDTH > blf_pkg::COURANT_WIDTH) ? SAMPLE_WIDTH
                        : blf_pkg::COURANT_WIDTH + 1) + 2*SAMPLE_WIDTH - 1:0] prod_o
);
  import blf_pkg::*;

  localparam int unsigned AW = (SAMPLE_WIDTH > COURANT_WIDTH) ? SAMPLE_WIDTH
                                                              : COURANT_WIDTH + 1;
  localparam int unsigned BW = 2 * SAMPLE_WIDTH;
  localparam int unsigned PW = AW + BW;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_d, prod_q;

  // operand select
  always_comb begin
    case (ctrl_i.sel)
      MUL_SQ_RIGHT: begin
        mul_a = AW'(right_i);
        mul_b = BW'(right_i);
      end
      MUL_SQ_LEFT: begin
        mul_a = AW'(left_i);
        mul_b = BW'(left_i);
      end
      MUL_SCALE: begin
        mul_a = signed'(AW'({1'b0, courant_i}));
        mul_b = diff_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // registered product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/burgers_lax_friedrichs_stencil_top.sv
// Streaming Lax-Friedrichs stencil for the 1-D inviscid Burgers equation. Samples of one
// grid row arrive in order with row_end_i on the last; each interior point leaves as
// 0.5*(uR+uL) - r*(uR^2-uL^2)/4, rounded to nearest and saturated, and the two end points
// leave unchanged. With alternate mode set only points whose index plus the row count is
// odd are updated. One request is handled at a time: a sample that gives no result leaves the
// sequencer idle, a pass-through result goes straight to the emit states (a trailing end
// point is emitted after it), and an updated point uses the one registered multiplier
// three times in sequence (right square, left square, scaled difference), with a subtract
// stage between the second and third use and a round/saturate stage after them. A finished
// result waits in the output register while the next request is taken.
module burgers_lax_friedrichs_stencil_top #(
  parameter int unsigned SAMPLE_WIDTH  = 16,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [blf_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr_i,
  input  logic [blf_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata_i,
  // sample input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  input  logic                                 row_end_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]       new_value_o,
  output logic                                 row_done_o
);
  import blf_pkg::*;

  localparam int unsigned AW = (SAMPLE_WIDTH > COURANT_WIDTH) ? SAMPLE_WIDTH
                                                              : COURANT_WIDTH + 1;
  localparam int unsigned DW = 2 * SAMPLE_WIDTH;
  localparam int unsigned PW = AW + DW;
  localparam int unsigned YW = PW + 2;

  localparam logic signed [YW-1:0] RND_HALF =
    {{(YW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);
  localparam logic signed [YW-1:0] Q_MAX =
    {{(YW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [YW-1:0] Q_MIN = ~Q_MAX;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQR   = 3'd1;
  localparam logic [2:0] ST_SQL   = 3'd2;
  localparam logic [2:0] ST_DIF   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_RND   = 3'd5;
  localparam logic [2:0] ST_EMIT1 = 3'd6;
  localparam logic [2:0] ST_EMIT2 = 3'd7;

  // configuration
  logic [COURANT_WIDTH-1:0] courant_q;
  logic                     alt_q;

  // stencil state
  logic signed [SAMPLE_WIDTH-1:0] left_q, center_q;
  logic [1:0]                     bcnt_q;
  logic                           codd_q, rpar_q;

  // per request working registers
  logic [2:0]                     state_q, state_d;
  logic signed [SAMPLE_WIDTH-1:0] opl_q, opr_q;
  logic signed [SAMPLE_WIDTH-1:0] res_q, res_d;
  logic                           res_done_q, second_q;
  logic signed [PW-1:0]           sqr_q;
  logic signed [DW-1:0]           diff_q;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_value_q;
  logic                           out_done_q;

  logic                           in_accept, do_update, out_free, out_load;
  mul_ctrl_t                      mul_ctrl;
  logic signed [PW-1:0]           prod;
  logic signed [PW:0]             neg_p;
  logic signed [SAMPLE_WIDTH:0]   sum;
  logic signed [YW-1:0]           y_val, q_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign do_update  = !alt_q || (codd_q ^ rpar_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = ((state_q == ST_EMIT1) || (state_q == ST_EMIT2)) && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      courant_q <= COURANT_RESET;
      alt_q     <= ALT_MODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_COURANT_RATIO:  courant_q <= cfg_wdata_i[COURANT_WIDTH-1:0];
        CFG_ALTERNATE_MODE: alt_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // stencil state advances when a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      center_q <= '0;
      bcnt_q   <= BUF_EMPTY;
      codd_q   <= 1'b0;
      rpar_q   <= 1'b0;
    end else if (in_accept) begin
      if (row_end_i) begin
        bcnt_q   <= BUF_EMPTY;
        codd_q   <= 1'b0;
        rpar_q   <= ~rpar_q;
        left_q   <= '0;
        center_q <= '0;
      end else if (bcnt_q == BUF_EMPTY) begin
        center_q <= sample_i;
        codd_q   <= 1'b0;
        bcnt_q   <= BUF_CENTER;
      end else begin
        left_q   <= center_q;
        center_q <= sample_i;
        codd_q   <= ~codd_q;
        bcnt_q   <= BUF_PAIR;
      end
    end
  end

  // next sequencer state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (bcnt_q == BUF_EMPTY) begin
            res_d   = sample_i;
            state_d = ST_EMIT1;
          end else if (bcnt_q == BUF_CENTER) begin
            res_d   = sample_i;
            state_d = row_end_i ? ST_EMIT1 : ST_IDLE;
          end else if (do_update) begin
            state_d = ST_SQR;
          end else begin
            res_d   = center_q;
            state_d = ST_EMIT1;
          end
        end
      end
      ST_SQR:   state_d = ST_SQL;
      ST_SQL:   state_d = ST_DIF;
      ST_DIF:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_RND;
      ST_RND: begin
        if (q_val > Q_MAX) begin
          res_d = Q_MAX[SAMPLE_WIDTH-1:0];
        end else if (q_val < Q_MIN) begin
          res_d = Q_MIN[SAMPLE_WIDTH-1:0];
        end else begin
          res_d = q_val[SAMPLE_WIDTH-1:0];
        end
        state_d = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (out_free) begin
          state_d = second_q ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request working registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_accept) begin
      opl_q      <= left_q;
      opr_q      <= sample_i;
      // a lone end point, or the last end point of a two-sample row, carries its own row_done flag
      res_done_q <= (bcnt_q == BUF_CENTER) || ((bcnt_q == BUF_EMPTY) && row_end_i);
      second_q   <= (bcnt_q != BUF_EMPTY) && (bcnt_q != BUF_CENTER) && row_end_i;
    end
    if (state_q == ST_SQL) begin
      sqr_q <= prod;
    end
    if (state_q == ST_DIF) begin
      diff_q <= DW'(sqr_q - prod);
    end
  end

  // shared multiplier control
  always_comb begin
    mul_ctrl.en  = 1'b0;
    mul_ctrl.sel = MUL_SQ_RIGHT;
    case (state_q)
      ST_SQR: begin
        mul_ctrl.en  = 1'b1;
        mul_ctrl.sel = MUL_SQ_RIGHT;
      end
      ST_SQL: begin
        mul_ctrl.en  = 1'b1;
        mul_ctrl.sel = MUL_SQ_LEFT;
      end
      ST_MUL: begin
        mul_ctrl.en  = 1'b1;
        mul_ctrl.sel = MUL_SCALE;
      end
      default: ;
    endcase
  end

  blf_mul #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mul (
    .clk_i    (clk_i),
    .ctrl_i   (mul_ctrl),
    .left_i   (opl_q),
    .right_i  (opr_q),
    .courant_i(courant_q),
    .diff_i   (diff_q),
    .prod_o   (prod)
  );

  // round: S/2 - ceil(r*D/2^split) at double fraction, then to nearest
  assign sum   = (SAMPLE_WIDTH+1)'(opl_q) + (SAMPLE_WIDTH+1)'(opr_q);
  assign neg_p = -((PW+1)'(prod));
  assign y_val = (YW'(sum) <<< (FRACTION_BITS - 1)) + YW'(neg_p >>> SPLIT_BITS) + RND_HALF;
  assign q_val = y_val >>> FRACTION_BITS;

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == ST_EMIT2) begin
        out_value_q <= opr_q;
        out_done_q  <= 1'b1;
      end else begin
        out_value_q <= res_q;
        out_done_q  <= res_done_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = out_value_q;
  assign row_done_o  = out_done_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && row_end_i) |=> (rpar_q != $past(rpar_q)))
    else $error("row parity did not toggle at row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQR) |=> (state_q == ST_SQL) ##1 (state_q == ST_DIF))
    else $error("multiplier sequence broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT2 && out_load) |=> (out_valid_o && row_done_o))
    else $error("trailing end point lost its row_done flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (bcnt_q == BUF_PAIR) && alt_q && (codd_q == rpar_q)) |=> (state_q != ST_SQR))
    else $error("checkerboard point was updated");

endmodule
